// ----- sv/bmp_pkg.sv -----
// ============================================================================
// bmp_pkg: shared types and constants of the BLE-MIDI packet parser
// Byte classification record, result record, parse phase codes and the
// MIDI status constants used by the front end and the parser.
// ============================================================================
package bmp_pkg;

  // Depths of the byte queue behind the front end and of the result queue.
  localparam int FrontDepth = 4;
  localparam int FrontPtrW  = $clog2(FrontDepth);
  localparam int FrontCntW  = $clog2(FrontDepth + 1);
  localparam int OutDepth   = 2;
  localparam int OutPtrW    = $clog2(OutDepth);
  localparam int OutCntW    = $clog2(OutDepth + 1);

  // Parse phases.
  localparam logic [2:0] PH_WAIT     = 3'd0;
  localparam logic [2:0] PH_BOUNDARY = 3'd1;
  localparam logic [2:0] PH_AFTER_TS = 3'd2;
  localparam logic [2:0] PH_DATA1    = 3'd3;
  localparam logic [2:0] PH_DATA2    = 3'd4;

  // Upper status nibbles.
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CTRL_CHG = 4'hB;

  // Event kind codes on the result port.
  localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_CTRL_CHG = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       start;      // header byte of a new packet
    logic       high;       // bit 7 set
    logic       supported;  // status kind that carries a two-byte message
  } byte_info_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  channel;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [12:0] timestamp;
  } event_t;

  function automatic logic kind_supported(input logic [7:0] status);
    return (status[7:4] == ST_NOTE_OFF) || (status[7:4] == ST_NOTE_ON) ||
           (status[7:4] == ST_CTRL_CHG);
  endfunction

endpackage

// ----- sv/bmp_front.sv -----
// ============================================================================
// bmp_front: byte intake and classification
// Takes raw packet bytes, tags them, and holds them in a short queue for
// the parser.
// ============================================================================
module bmp_front import bmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] data_byte_i,
  input  logic       packet_start_i,
  output logic       valid_o,
  output byte_info_t info_o,
  input  logic       pop_i
);

  byte_info_t                 mem_q [FrontDepth];
  logic [FrontPtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [FrontCntW-1:0]       count_q;
  logic                       do_push, do_pop;
  byte_info_t                 info_in;

  assign full_o  = (count_q == FrontCntW'(FrontDepth));
  assign valid_o = (count_q != '0);
  assign info_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    info_in.data      = data_byte_i;
    info_in.start     = packet_start_i;
    info_in.high      = data_byte_i[7];
    info_in.supported = kind_supported(data_byte_i);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= info_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/bmp_parser.sv -----
// ============================================================================
// bmp_parser: message parser
// Walks the classified bytes through the BLE-MIDI message phases and emits
// note and control change events.
// ============================================================================
module bmp_parser import bmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  byte_info_t info_i,
  output logic       pop_o,
  input  logic       ev_full_i,
  output logic       ev_push_o,
  output event_t     ev_o
);

  logic [2:0] phase_q, phase_d;
  logic [7:0] status_q, status_d;
  logic [5:0] stamp_high_q, stamp_high_d;
  logic [6:0] stamp_low_q, stamp_low_d;
  logic [7:0] held_q, held_d;

  // A byte is taken only when a result it may cause has room.
  assign pop_o = valid_i && !ev_full_i;

  always_comb begin
    phase_d      = phase_q;
    status_d     = status_q;
    stamp_high_d = stamp_high_q;
    stamp_low_d  = stamp_low_q;
    held_d       = held_q;
    ev_push_o    = 1'b0;
    ev_o.kind        = KIND_NOTE_OFF;
    ev_o.channel     = status_q[3:0];
    ev_o.first_data  = held_q;
    ev_o.second_data = info_i.data;
    ev_o.timestamp   = {stamp_high_q, stamp_low_q};

    if (pop_o) begin
      if (info_i.start) begin
        stamp_high_d = info_i.data[5:0];
        stamp_low_d  = '0;
        status_d     = '0;
        phase_d      = PH_BOUNDARY;
      end else begin
        case (phase_q)
          PH_BOUNDARY, PH_AFTER_TS: begin
            if (info_i.high && phase_q == PH_BOUNDARY) begin
              stamp_low_d = info_i.data[6:0];
              phase_d     = PH_AFTER_TS;
            end else if (info_i.high) begin
              status_d = info_i.data;
              phase_d  = info_i.supported ? PH_DATA1 : PH_BOUNDARY;
            end else if (kind_supported(status_q)) begin
              held_d  = info_i.data;
              phase_d = PH_DATA2;
            end else begin
              phase_d = PH_BOUNDARY;
            end
          end
          PH_DATA1: begin
            held_d  = info_i.data;
            phase_d = PH_DATA2;
          end
          PH_DATA2: begin
            phase_d = PH_BOUNDARY;
            case (status_q[7:4])
              ST_NOTE_OFF: begin
                ev_o.kind = KIND_NOTE_OFF;
                ev_push_o = 1'b1;
              end
              ST_NOTE_ON: begin
                ev_o.kind = KIND_NOTE_ON;
                ev_push_o = (info_i.data != 8'd0);
              end
              ST_CTRL_CHG: begin
                ev_o.kind = KIND_CTRL_CHG;
                ev_push_o = 1'b1;
              end
              default: ev_push_o = 1'b0;
            endcase
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WAIT;
      status_q     <= '0;
      stamp_high_q <= '0;
      stamp_low_q  <= '0;
      held_q       <= '0;
    end else begin
      phase_q      <= phase_d;
      status_q     <= status_d;
      stamp_high_q <= stamp_high_d;
      stamp_low_q  <= stamp_low_d;
      held_q       <= held_d;
    end
  end

  // An event only closes a message whose second data byte is being taken.
  a_event_from_data2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_push_o |-> (pop_o && !info_i.start && phase_q == PH_DATA2))
    else $error("event emitted outside the second data phase");

  // A header byte always lands the parser on a clean message boundary.
  a_header_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && info_i.start) |=> (phase_q == PH_BOUNDARY && status_q == 8'd0 &&
                                 stamp_low_q == 7'd0))
    else $error("header byte did not reset the parse state");

  // A stalled parser leaves its state untouched.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> ($stable(phase_q) && $stable(status_q) && $stable(held_q)))
    else $error("parse state moved while no byte was taken");

endmodule

// ----- sv/bmp_out_queue.sv -----
// ============================================================================
// bmp_out_queue: result queue
// Two-entry queue of finished events in front of the result port.
// ============================================================================
module bmp_out_queue import bmp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  event_t ev_i,
  output logic   full_o,
  output logic   empty_o,
  input  logic   pop_i,
  output event_t ev_o
);

  event_t             mem_q [OutDepth];
  logic [OutPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OutCntW-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == OutCntW'(OutDepth));
  assign empty_o = (count_q == '0);
  assign ev_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/ble_midi_packet_parser_top.sv -----
// ============================================================================
// ble_midi_packet_parser_top: BLE-MIDI packet parser
// Parses a stream of BLE-MIDI packet bytes into note off, note on and
// control change events with their 13-bit timestamps.
// ============================================================================
//
//  Channel  Direction  Handshake            Item
//  -------  ---------  -------------------  ---------------------------------
//  input    in         push / full          data_byte_i, packet_start_i
//  result   out        empty / pop          event_kind_o, channel_o,
//                                           first_data_o, second_data_o,
//                                           timestamp_o
//
//  One byte is accepted per cycle when neither queue backs up. An event
//  reaches the result ports once the byte closing it is stored in the
//  byte queue and its event in the result queue. The rate is set by the
//  parser, which retires one byte per cycle while the result queue has room.
//  Reset is asynchronous and active low; afterwards the parser waits for
//  a header byte and both queues are empty.
//  A stalled result side fills the two-entry result queue, then the parser
//  stops and the four-entry byte queue absorbs input before full rises.
//
module ble_midi_packet_parser_top import bmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        packet_start_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  event_kind_o,
  output logic [3:0]  channel_o,
  output logic [7:0]  first_data_o,
  output logic [7:0]  second_data_o,
  output logic [12:0] timestamp_o
);

  // Classified bytes waiting for the parser.
  logic       byte_valid;
  byte_info_t byte_info;
  logic       byte_pop;

  // Events on their way to the result queue.
  logic   ev_push;
  logic   ev_full;
  event_t ev_new;
  event_t ev_head;

  // Front end: tags each byte and buffers it so a parser stall holds the
  // input only once the byte queue is full.
  bmp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .data_byte_i    (data_byte_i),
    .packet_start_i (packet_start_i),
    .valid_o        (byte_valid),
    .info_o         (byte_info),
    .pop_i          (byte_pop)
  );

  // Back end: the message state machine. It takes a byte only when the
  // result queue has room for the event that byte might produce.
  bmp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (byte_valid),
    .info_i    (byte_info),
    .pop_o     (byte_pop),
    .ev_full_i (ev_full),
    .ev_push_o (ev_push),
    .ev_o      (ev_new)
  );

  // Result queue: decouples the parser from the consumer.
  bmp_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .ev_i    (ev_new),
    .full_o  (ev_full),
    .empty_o (empty),
    .pop_i   (pop),
    .ev_o    (ev_head)
  );

  assign event_kind_o  = ev_head.kind;
  assign channel_o     = ev_head.channel;
  assign first_data_o  = ev_head.first_data;
  assign second_data_o = ev_head.second_data;
  assign timestamp_o   = ev_head.timestamp;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking testbench of the BLE-MIDI packet parser
// Feeds packet bytes through the push/full side and predicts every event
// with a cycle-free model of the parser. Each event popped from the result
// side is compared field by field with the oldest prediction. Directed
// packets cover the corner cases. Random packets with random gaps and
// stalls on both sides follow, then a burst without gaps and random noise.
// ============================================================================
module tb;
  import bmp_pkg::*;

  // --------------------------------------------------------------------------
  // Clock, reset and the ports of the parser. Every input has a known value
  // from time zero.
  // --------------------------------------------------------------------------
  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        push         = 1'b0;
  logic        full;
  logic [7:0]  data_byte    = 8'h00;
  logic        packet_start = 1'b0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [1:0]  event_kind;
  logic [3:0]  channel;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [12:0] timestamp;

  always #2 clk = ~clk;

  ble_midi_packet_parser_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte),
    .packet_start_i (packet_start),
    .empty          (empty),
    .pop            (pop),
    .event_kind_o   (event_kind),
    .channel_o      (channel),
    .first_data_o   (first_data),
    .second_data_o  (second_data),
    .timestamp_o    (timestamp)
  );

  // When gaps_on is set, the sender inserts idle gaps before bytes and the
  // receiver holds off pop, each at random with a chance of about 22 percent.
  // Clearing it gives a long stretch in which both sides run at full rate.
  bit gaps_on     = 1'b1;
  int error_count = 0;
  int bytes_sent  = 0;

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the parser: the phase within a message, the
  // status in force, both halves of the timestamp and the first data byte.
  // --------------------------------------------------------------------------
  logic [2:0] phase_m      = PH_WAIT;
  logic [7:0] status_m     = 8'h00;
  logic [5:0] stamp_high_m = 6'd0;
  logic [6:0] stamp_low_m  = 7'd0;
  logic [7:0] held_m       = 8'h00;

  // Events that the parser owes us, oldest first.
  event_t pending_events[$];

  // True for the three status kinds that carry two data bytes.
  function automatic logic two_byte_status(input logic [7:0] status);
    return (status[7:4] == ST_NOTE_OFF) || (status[7:4] == ST_NOTE_ON) ||
           (status[7:4] == ST_CTRL_CHG);
  endfunction

  // A data byte at a message boundary continues the status in force, or is
  // skipped when that status carries no two-byte message.
  task automatic continue_running(input logic [7:0] value);
    if (two_byte_status(status_m)) begin
      held_m  = value;
      phase_m = PH_DATA2;
    end else begin
      phase_m = PH_BOUNDARY;
    end
  endtask

  // Advances the predictor by one accepted byte and queues the event that
  // the byte completes, if any.
  task automatic parse_byte(input logic [7:0] value, input logic is_header);
    event_t ev;
    logic   emit;
    emit = 1'b0;
    if (is_header) begin
      // A header always wins, even in the middle of a message.
      stamp_high_m = value[5:0];
      stamp_low_m  = 7'd0;
      status_m     = 8'h00;
      phase_m      = PH_BOUNDARY;
    end else begin
      case (phase_m)
        PH_BOUNDARY: begin
          if (value[7]) begin
            stamp_low_m = value[6:0];
            phase_m     = PH_AFTER_TS;
          end else begin
            continue_running(value);
          end
        end
        PH_AFTER_TS: begin
          if (value[7]) begin
            status_m = value;
            phase_m  = two_byte_status(value) ? PH_DATA1 : PH_BOUNDARY;
          end else begin
            continue_running(value);
          end
        end
        PH_DATA1: begin
          // Taken as data whatever bit 7 holds.
          held_m  = value;
          phase_m = PH_DATA2;
        end
        PH_DATA2: begin
          phase_m        = PH_BOUNDARY;
          ev.channel     = status_m[3:0];
          ev.first_data  = held_m;
          ev.second_data = value;
          ev.timestamp   = {stamp_high_m, stamp_low_m};
          if (status_m[7:4] == ST_NOTE_OFF) begin
            ev.kind = KIND_NOTE_OFF;
            emit    = 1'b1;
          end else if (status_m[7:4] == ST_NOTE_ON) begin
            // Note on with zero velocity yields nothing.
            ev.kind = KIND_NOTE_ON;
            emit    = (value != 8'h00);
          end else if (status_m[7:4] == ST_CTRL_CHG) begin
            ev.kind = KIND_CTRL_CHG;
            emit    = 1'b1;
          end
        end
        default: ;  // no header seen yet: the byte is ignored
      endcase
    end
    if (emit) pending_events.push_back(ev);
  endtask

  // --------------------------------------------------------------------------
  // Result side. pop changes at the falling edge; an event is taken at the
  // rising edge where pop is high and empty is low, and checked right there.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    pop <= gaps_on ? ($urandom_range(99) >= 22) : 1'b1;
  end

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, what,
               want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    event_t want;
    if (rst_n && pop && !empty) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual kind %0d ch %0h %0h %0h ts %0h",
                 $realtime, event_kind, channel, first_data, second_data, timestamp);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", 32'(want.kind), 32'(event_kind));
        check_field("channel", 32'(want.channel), 32'(channel));
        check_field("first_data", 32'(want.first_data), 32'(first_data));
        check_field("second_data", 32'(want.second_data), 32'(second_data));
        check_field("timestamp", 32'(want.timestamp), 32'(timestamp));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side. Every send task is entered just after a falling edge and
  // returns just after one, so push is assigned at most once per time step
  // and stays high between back-to-back items.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] value, input logic is_header);
    while (gaps_on && $urandom_range(99) < 22) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    data_byte    <= value;
    packet_start <= is_header;
    do @(posedge clk); while (full);
    parse_byte(value, is_header);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Holds the input side off until every predicted event has come out, then
  // lets the byte queue and the parser pipeline run dry.
  task automatic drain_events();
    push <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Data values are mostly proper 7-bit MIDI data, sometimes with bit 7 set.
  function automatic logic [7:0] random_data();
    logic [7:0] v;
    if ($urandom_range(99) < 88) v = 8'($urandom_range(127));
    else v = 8'($urandom_range(255, 128));
    return v;
  endfunction

  // Mostly the three supported kinds on a random channel, now and then a
  // status kind the parser has to skip.
  function automatic logic [7:0] random_status();
    logic [3:0] upper;
    logic [3:0] chan;
    chan = 4'($urandom_range(15));
    if ($urandom_range(99) < 85) begin
      case ($urandom_range(2))
        0:       upper = ST_NOTE_OFF;
        1:       upper = ST_NOTE_ON;
        default: upper = ST_CTRL_CHG;
      endcase
    end else begin
      upper = 4'($urandom_range(15, 10));
      if (upper == ST_CTRL_CHG) upper = 4'hA;
    end
    return {upper, chan};
  endfunction

  // One well-formed packet with random content: a header, then a few
  // messages, each with or without a timestamp byte and a status byte.
  // With may_break set, a message is sometimes cut short by the next
  // header, which the caller sends.
  task automatic send_random_packet(input bit may_break);
    logic       have_status;
    logic       with_stamp;
    logic [7:0] second;
    int         messages;
    have_status = 1'b0;
    messages    = $urandom_range(6, 1);
    send_byte(8'($urandom_range(255)), 1'b1);
    for (int m = 0; m < messages; m++) begin
      with_stamp = !have_status || ($urandom_range(99) < 50);
      if (with_stamp) begin
        send_byte({1'b1, 7'($urandom_range(127))}, 1'b0);
        if (!have_status || $urandom_range(99) < 50) begin
          send_byte(random_status(), 1'b0);
          have_status = 1'b1;
        end
      end
      send_byte(random_data(), 1'b0);
      if (may_break && $urandom_range(99) < 8) return;
      second = ($urandom_range(99) < 10) ? 8'h00 : random_data();
      send_byte(second, 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Before the first header, bytes are ignored, status-like ones included.
  task automatic test_before_header();
    send_byte(8'h90, 1'b0);
    send_byte(8'h45, 1'b0);
  endtask

  // Extreme timestamps, all three kinds, data bytes with bit 7 set, running
  // status with and without a timestamp, and a note on with zero velocity.
  task automatic test_message_kinds();
    send_byte(8'hFF, 1'b1);  // header, high timestamp bits all ones
    send_byte(8'hFF, 1'b0);  // low timestamp all ones
    send_byte(8'h9F, 1'b0);  // note on, channel 15
    send_byte(8'hFF, 1'b0);  // note byte with bit 7 set is still data
    send_byte(8'h80, 1'b0);  // velocity byte with bit 7 set too
    send_byte(8'h00, 1'b0);  // running status without a timestamp
    send_byte(8'h00, 1'b0);  // zero velocity: dropped
    send_byte(8'h80, 1'b0);  // low timestamp zero
    send_byte(8'h80, 1'b0);  // note off, channel 0
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h81, 1'b0);  // timestamp, then a data byte under running
    send_byte(8'h33, 1'b0);  // status, which is the note off above
    send_byte(8'h7F, 1'b0);
    send_byte(8'hB3, 1'b0);  // after that message, a status-like byte is a
    send_byte(8'hB3, 1'b0);  // timestamp, so a second one sets control change
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  // An unsupported status, and no status at all after a header, both make
  // the parser skip data bytes one at a time.
  task automatic test_skipped_data();
    send_byte(8'h82, 1'b0);  // timestamp
    send_byte(8'hE0, 1'b0);  // pitch bend: not supported
    send_byte(8'h12, 1'b0);  // skipped
    send_byte(8'h40, 1'b1);  // header, high timestamp bits zero
    send_byte(8'h15, 1'b0);  // no status in force: skipped
  endtask

  // A header in the middle of a message drops the partial message.
  task automatic test_truncated_message();
    send_byte(8'h83, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC0, 1'b1);  // new packet before the velocity byte
    send_byte(8'h64, 1'b0);  // running status was cleared: skipped
  endtask

  // Random packets, some cut short by the next header, with gaps on both sides.
  task automatic test_random_packets(input int byte_count);
    int stop_at;
    stop_at = bytes_sent + byte_count;
    while (bytes_sent < stop_at) send_random_packet(1'b1);
  endtask

  // A long stretch in which neither side ever idles.
  task automatic test_full_rate_burst(input int byte_count);
    int stop_at;
    stop_at = bytes_sent + byte_count;
    gaps_on = 1'b0;
    while (bytes_sent < stop_at) send_random_packet(1'b0);
    gaps_on = 1'b1;
  endtask

  // Unstructured bytes, with a header now and then.
  task automatic test_random_noise(input int byte_count);
    repeat (byte_count) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run. Reset is held from time zero and released at a
  // falling edge; after the stimulus the run waits for every event owed.
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_before_header();
    test_message_kinds();
    test_skipped_data();
    test_truncated_message();
    drain_events();

    test_random_packets(280);
    drain_events();
    test_full_rate_burst(120);
    test_random_noise(70);

    drain_events();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of about 500 bytes.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
